[hw/rtl/mcbp_pkg.sv]
// ----------------------------------------------------------------------------
// mcbp_pkg
// Shared types and codes of the multi-channel byte pipe: request and status
// codes and the byte type carried between the control logic and the store.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbp_pkg;

    typedef logic [7:0] byte_t;

    localparam logic [1:0] REQ_OPEN  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_SLOT      = 3'd1;
    localparam logic [2:0] ST_NO_PIPE      = 3'd2;
    localparam logic [2:0] ST_WR_CLOSED    = 3'd3;
    localparam logic [2:0] ST_EMPTY_CLOSED = 3'd4;
    localparam logic [2:0] ST_FULL         = 3'd5;
    localparam logic [2:0] ST_EMPTY_RETRY  = 3'd6;

endpackage

`default_nettype wire

[hw/rtl/mcbp_store.sv]
// ----------------------------------------------------------------------------
// mcbp_store
// Shared byte store of all pipes: one write port, one read port, registered
// read data. Contents are undefined after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbp_store #(
    parameter int DEPTH = 1280,
    parameter int AW    = 11
) (
    input  wire                 clk,
    input  wire                 we,
    input  wire [AW-1:0]        waddr,
    input  mcbp_pkg::byte_t     wdata,
    input  wire                 re,
    input  wire [AW-1:0]        raddr,
    output mcbp_pkg::byte_t     rdata
);

    mcbp_pkg::byte_t mem [DEPTH];
    mcbp_pkg::byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/multi_channel_byte_pipe_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_top
// Bank of NUM_PIPES byte pipes, each a ring buffer in its own region of one
// shared byte store.
//
// Requests enter on the in channel (req_type, pipe_id, open_size, write_byte)
// and each gives exactly one word on the out channel (status, slot_given,
// read_byte), both valid/ready.
// For open, write, close and failed reads the result is registered at the edge
// that accepts the request. A read that returns a byte passes through S_READ,
// since the byte store registers its read data; no new request is taken in
// S_READ.
// A new request is taken while the previous result is held, as long as that
// result is taken in the same cycle; while the receiver stalls with a result
// pending, in_ready stays low.
// Reset frees all slots and clears all pointers and counts; the byte store is
// not cleared and needs no clearing pass, since only written bytes are read.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_byte_pipe_top #(
    parameter int NUM_PIPES = 5,
    parameter int MAX_DEPTH = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [1:0] req_type,
    input  wire  [2:0] pipe_id,
    input  wire  [8:0] open_size,
    input  wire  [7:0] write_byte,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [2:0] status,
    output logic [2:0] slot_given,
    output logic [7:0] read_byte
);

    localparam int IW    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PW    = $clog2(MAX_DEPTH);
    localparam int CW    = $clog2(MAX_DEPTH + 1);
    localparam int LW    = (CW > 9) ? CW : 9;
    localparam int DEPTH = NUM_PIPES * MAX_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {S_IDLE, S_READ} state_t;

    state_t          state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      status_reg, status_next;
    logic [2:0]      slot_reg, slot_next;
    mcbp_pkg::byte_t rbyte_reg, rbyte_next;

    logic [CW-1:0]   cap_reg    [NUM_PIPES];
    logic [PW-1:0]   head_reg   [NUM_PIPES];
    logic [PW-1:0]   tail_reg   [NUM_PIPES];
    logic [CW-1:0]   fill_reg   [NUM_PIPES];
    logic            closed_reg [NUM_PIPES];

    logic            acc;
    logic [IW-1:0]   sel;
    logic            in_range;
    logic            live;
    logic            free_found;
    logic [IW-1:0]   free_idx;
    logic [LW-1:0]   size_ext;
    logic [CW-1:0]   cap_new;
    logic [2:0]      res_status;
    logic            do_open, do_write, do_close, do_read;
    logic [CW-1:0]   cap_sel, fill_sel;
    logic [CW-1:0]   tail_inc, head_inc;
    logic [PW-1:0]   tail_adv, head_adv;
    logic [AW-1:0]   slot_base;
    logic [AW-1:0]   waddr, raddr;
    mcbp_pkg::byte_t rdata;
    logic            fill_ok;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign acc      = in_valid && in_ready;
    assign sel      = pipe_id[IW-1:0];
    assign in_range = ({1'b0, pipe_id} < 4'(NUM_PIPES));

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (cap_reg[i] == '0)
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // clamp the requested size to 1 .. MAX_DEPTH
    always_comb
    begin
        size_ext = LW'(open_size);
        if (size_ext == '0)
        begin
            size_ext = LW'(1);
        end
        if (size_ext > LW'(MAX_DEPTH))
        begin
            size_ext = LW'(MAX_DEPTH);
        end
        cap_new = size_ext[CW-1:0];
    end

    always_comb
    begin
        cap_sel  = in_range ? cap_reg[sel] : '0;
        fill_sel = in_range ? fill_reg[sel] : '0;
        live     = in_range && (cap_sel != '0);
        tail_inc = CW'(tail_reg[sel]) + CW'(1);
        head_inc = CW'(head_reg[sel]) + CW'(1);
        tail_adv = (tail_inc >= cap_sel) ? '0 : tail_inc[PW-1:0];
        head_adv = (head_inc >= cap_sel) ? '0 : head_inc[PW-1:0];
    end

    // request decode
    always_comb
    begin
        res_status = mcbp_pkg::ST_OK;
        do_open    = 1'b0;
        do_write   = 1'b0;
        do_close   = 1'b0;
        do_read    = 1'b0;
        if (req_type == mcbp_pkg::REQ_OPEN)
        begin
            if (free_found)
            begin
                do_open = 1'b1;
            end
            else
            begin
                res_status = mcbp_pkg::ST_NO_SLOT;
            end
        end
        else if (!live)
        begin
            res_status = mcbp_pkg::ST_NO_PIPE;
        end
        else
        begin
            case (req_type)
                mcbp_pkg::REQ_WRITE:
                begin
                    if (closed_reg[sel])
                    begin
                        res_status = mcbp_pkg::ST_WR_CLOSED;
                    end
                    else if (fill_sel >= cap_sel)
                    begin
                        res_status = mcbp_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_write = 1'b1;
                    end
                end
                mcbp_pkg::REQ_CLOSE:
                begin
                    do_close = 1'b1;
                end
                mcbp_pkg::REQ_READ:
                begin
                    if (fill_sel == '0)
                    begin
                        res_status = closed_reg[sel] ? mcbp_pkg::ST_EMPTY_CLOSED
                                                     : mcbp_pkg::ST_EMPTY_RETRY;
                    end
                    else
                    begin
                        do_read = 1'b1;
                    end
                end
                default:
                begin
                    res_status = mcbp_pkg::ST_OK;
                end
            endcase
        end
    end

    assign slot_base = AW'(sel) * AW'(MAX_DEPTH);
    assign waddr     = slot_base + AW'(tail_reg[sel]);
    assign raddr     = slot_base + AW'(head_reg[sel]);

    mcbp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (acc && do_write),
        .waddr (waddr),
        .wdata (write_byte),
        .re    (acc && do_read),
        .raddr (raddr),
        .rdata (rdata)
    );

    // per-slot pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                cap_reg[i]    <= '0;
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                fill_reg[i]   <= '0;
                closed_reg[i] <= 1'b0;
            end
        end
        else if (acc)
        begin
            if (do_open)
            begin
                cap_reg[free_idx]    <= cap_new;
                head_reg[free_idx]   <= '0;
                tail_reg[free_idx]   <= '0;
                fill_reg[free_idx]   <= '0;
                closed_reg[free_idx] <= 1'b0;
            end
            if (do_write)
            begin
                tail_reg[sel] <= tail_adv;
                fill_reg[sel] <= fill_sel + CW'(1);
            end
            if (do_close)
            begin
                closed_reg[sel] <= 1'b1;
            end
            if (do_read)
            begin
                head_reg[sel] <= head_adv;
                fill_reg[sel] <= fill_sel - CW'(1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        rbyte_next     = rbyte_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (do_read)
                    begin
                        state_next     = S_READ;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next    = res_status;
                        slot_next      = do_open ? 3'(free_idx) : 3'd0;
                        rbyte_next     = '0;
                    end
                end
                else if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                status_next    = mcbp_pkg::ST_OK;
                slot_next      = 3'd0;
                rbyte_next     = rdata;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= mcbp_pkg::ST_OK;
            slot_reg      <= 3'd0;
            rbyte_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            rbyte_reg     <= rbyte_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_given = slot_reg;
    assign read_byte  = rbyte_reg;

    always_comb
    begin
        fill_ok = 1'b1;
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            if (fill_reg[i] > cap_reg[i])
            begin
                fill_ok = 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_ok)
        else $error("pipe fill count above its capacity");

    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !in_ready)
        else $error("request taken while a read is in flight");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> out_valid && status == mcbp_pkg::ST_OK)
        else $error("read result not presented after store access");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mcbp_pkg::ST_OK |-> read_byte == 8'd0 && slot_given == 3'd0)
        else $error("unused result fields not zero on an error word");

endmodule

`default_nettype wire
